// ===== sv/gbs_pkg.sv =====
// shared types, constants and helpers of the grid bucket corner selector
`default_nettype none
package gbs_pkg;

  localparam int MAX_CELLS  = 1024;
  localparam int MAX_LEVELS = 8;
  localparam int CELL_AW    = $clog2(MAX_CELLS);

  localparam int CMD_W   = 2;
  localparam int X_W     = 12;
  localparam int LVL_W   = 3;
  localparam int SCORE_W = 32;
  localparam int SEL_W   = 10;
  localparam int CSIZE_W = 8;
  localparam int GCOL_W  = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // input word layout
  localparam int IN_X_LSB     = 0;
  localparam int IN_Y_LSB     = IN_X_LSB + X_W;
  localparam int IN_LVL_LSB   = IN_Y_LSB + X_W;
  localparam int IN_SCORE_LSB = IN_LVL_LSB + LVL_W;
  localparam int IN_SEL_LSB   = IN_SCORE_LSB + SCORE_W;
  localparam int IN_BITS      = IN_SEL_LSB + SEL_W;
  localparam int IN_DATA_W    = ((IN_BITS + 7) / 8) * 8;

  // output word layout
  localparam int OUT_X_LSB     = 0;
  localparam int OUT_Y_LSB     = OUT_X_LSB + X_W;
  localparam int OUT_LVL_LSB   = OUT_Y_LSB + X_W;
  localparam int OUT_SCORE_LSB = OUT_LVL_LSB + LVL_W;
  localparam int OUT_BITS      = OUT_SCORE_LSB + SCORE_W;
  localparam int OUT_DATA_W    = ((OUT_BITS + 7) / 8) * 8;

  // scaled coordinate keeps the bits shifted out so overflow can be seen
  localparam int SHIFT_W = X_W + (1 << LVL_W) - 1;
  localparam int PROD_W  = X_W + GCOL_W;
  localparam int IDX_W   = PROD_W + 1;

  // divider retires two quotient bits per cycle
  localparam int DIV_STEPS = X_W / 2;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  localparam logic [CMD_W-1:0] CMD_MARK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_OFFER = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd2;

  localparam logic [CSIZE_W-1:0] CELL_SIZE_RST = 8'd16;
  localparam logic [GCOL_W-1:0]  GRID_COLS_RST = 11'd32;

  typedef struct packed {
    logic               occ;
    logic               bval;
    logic [X_W-1:0]     x;
    logic [X_W-1:0]     y;
    logic [LVL_W-1:0]   lvl;
    logic [SCORE_W-1:0] score;
  } entry_t;

  typedef struct packed {
    logic           done;
    logic [X_W-1:0] quo;
  } div_res_t;

  // one restoring step: {quotient bit, new remainder}
  function automatic logic [CSIZE_W:0] div_step(input logic [CSIZE_W-1:0] rem,
                                                input logic b,
                                                input logic [CSIZE_W-1:0] d);
    logic [CSIZE_W:0] trial;
    logic [CSIZE_W:0] diff;
    trial = {rem, b};
    diff  = trial - {1'b0, d};
    if (trial >= {1'b0, d}) begin
      div_step = {1'b1, diff[CSIZE_W-1:0]};
    end else begin
      div_step = {1'b0, trial[CSIZE_W-1:0]};
    end
  endfunction

endpackage
`default_nettype wire

// ===== sv/gbs_div.sv =====
// iterative coordinate divider, two quotient bits per cycle
`default_nettype none
module gbs_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [gbs_pkg::X_W-1:0]      dividend_i,
  input  wire logic [gbs_pkg::CSIZE_W-1:0]  divisor_i,
  output gbs_pkg::div_res_t                 res_o
);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [gbs_pkg::DIV_CW-1:0]   cnt_q, cnt_d;
  logic [gbs_pkg::CSIZE_W-1:0]  rem_q, rem_d;
  logic [gbs_pkg::X_W-1:0]      dvd_q, dvd_d;
  logic [gbs_pkg::CSIZE_W:0]    s1, s2;

  always_comb begin
    s1 = gbs_pkg::div_step(rem_q, dvd_q[gbs_pkg::X_W-1], divisor_i);
    s2 = gbs_pkg::div_step(s1[gbs_pkg::CSIZE_W-1:0], dvd_q[gbs_pkg::X_W-2], divisor_i);
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvd_d  = dividend_i;
    end else if (busy_q) begin
      // dividend shifts out at the top while quotient bits enter below
      rem_d = s2[gbs_pkg::CSIZE_W-1:0];
      dvd_d = {dvd_q[gbs_pkg::X_W-3:0], s1[gbs_pkg::CSIZE_W], s2[gbs_pkg::CSIZE_W]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == gbs_pkg::DIV_CW'(gbs_pkg::DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
  end

  assign res_o.done = done_q;
  assign res_o.quo  = dvd_q;

endmodule
`default_nettype wire

// ===== sv/gbs_mem.sv =====
// cell store: one write and one registered read per cycle
`default_nettype none
module gbs_mem (
  input  wire logic                         clk_i,
  input  wire logic                         we_i,
  input  wire logic [gbs_pkg::CELL_AW-1:0]  waddr_i,
  input  wire gbs_pkg::entry_t              wdata_i,
  input  wire logic [gbs_pkg::CELL_AW-1:0]  raddr_i,
  output gbs_pkg::entry_t                   rdata_o
);

  gbs_pkg::entry_t mem_q [gbs_pkg::MAX_CELLS];
  gbs_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== sv/grid_bucket_best_corner_select.sv =====
// top level: sequencer around the shared divider and the cell store
//
// channel   direction  handshake                     content
// s_axis    in         s_axis_tvalid/s_axis_tready   command word
// m_axis    out        m_axis_tvalid/m_axis_tready   read-back word of one cell
// cfg       in         cfg_valid_i/cfg_ready_o       register index and value
//
// mark and offer run two passes of the shared divider (six steps and a done cycle each),
// then multiply-add for the cell number, a store read and a write-back.
// an off-grid cell ends after the multiply-add; a word dropped up front never leaves idle.
// a read goes through the store read and write-back, then waits for the output register.
// after reset a clearing pass over all 1024 cells runs before the first word is taken.
// the output register holds a result while the next word is accepted.
`default_nettype none
module grid_bucket_best_corner_select (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output      logic                            s_axis_tready,
  // x_coord, y_coord, pyramid_level, score, cell_index, zero pad
  input  wire logic [gbs_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // command
  input  wire logic [gbs_pkg::CMD_W-1:0]       s_axis_tuser,
  output      logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // corner_x, corner_y, corner_level, corner_score, zero pad
  output      logic [gbs_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // cell_valid
  output      logic [0:0]                      m_axis_tuser,
  input  wire logic                            cfg_valid_i,
  output      logic                            cfg_ready_o,
  input  wire logic [gbs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [gbs_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DIVX  = 3'd2;
  localparam logic [2:0] ST_DIVY  = 3'd3;
  localparam logic [2:0] ST_MUL   = 3'd4;
  localparam logic [2:0] ST_RD    = 3'd5;
  localparam logic [2:0] ST_UPD   = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  logic [2:0]                      state_q, state_d;
  logic [gbs_pkg::CELL_AW-1:0]     clr_q, clr_d;
  logic [gbs_pkg::CMD_W-1:0]       cmd_q, cmd_d;
  logic [gbs_pkg::X_W-1:0]         px_q, px_d, py_q, py_d;
  logic [gbs_pkg::X_W-1:0]         col_q, col_d, row_q, row_d;
  logic [gbs_pkg::LVL_W-1:0]       lvl_q, lvl_d;
  logic [gbs_pkg::SCORE_W-1:0]     score_q, score_d;
  logic [gbs_pkg::CELL_AW-1:0]     addr_q, addr_d;
  gbs_pkg::entry_t                 res_q, res_d;

  logic [gbs_pkg::CSIZE_W-1:0]     cell_size_q;
  logic [gbs_pkg::GCOL_W-1:0]      grid_cols_q;
  logic [gbs_pkg::SCORE_W-1:0]     thr_q;

  logic                            m_valid_q, m_valid_d;
  logic [gbs_pkg::OUT_DATA_W-1:0]  m_data_q, m_data_d;
  logic                            m_user_q, m_user_d;

  // input fields
  logic [gbs_pkg::CMD_W-1:0]       in_cmd;
  logic [gbs_pkg::X_W-1:0]         in_x, in_y;
  logic [gbs_pkg::LVL_W-1:0]       in_lvl, lvl_eff;
  logic [gbs_pkg::SCORE_W-1:0]     in_score;
  logic [gbs_pkg::SEL_W-1:0]       in_sel;
  logic [gbs_pkg::SHIFT_W-1:0]     sx_w, sy_w;
  logic                            scale_ovf;
  logic                            in_acc;

  logic                            div_start;
  logic [gbs_pkg::X_W-1:0]         div_dvd;
  gbs_pkg::div_res_t               div_res;

  logic [gbs_pkg::PROD_W-1:0]      prod;
  logic [gbs_pkg::IDX_W-1:0]       idx;

  logic                            mem_we;
  logic [gbs_pkg::CELL_AW-1:0]     mem_waddr;
  gbs_pkg::entry_t                 mem_wdata, mem_rdata;
  logic                            keep;
  logic                            out_free;

  assign in_cmd   = s_axis_tuser;
  assign in_x     = s_axis_tdata[gbs_pkg::IN_X_LSB +: gbs_pkg::X_W];
  assign in_y     = s_axis_tdata[gbs_pkg::IN_Y_LSB +: gbs_pkg::X_W];
  assign in_lvl   = s_axis_tdata[gbs_pkg::IN_LVL_LSB +: gbs_pkg::LVL_W];
  assign in_score = s_axis_tdata[gbs_pkg::IN_SCORE_LSB +: gbs_pkg::SCORE_W];
  assign in_sel   = s_axis_tdata[gbs_pkg::IN_SEL_LSB +: gbs_pkg::SEL_W];

  // marks are already at full resolution
  assign lvl_eff   = (in_cmd == gbs_pkg::CMD_OFFER) ? in_lvl : '0;
  assign sx_w      = gbs_pkg::SHIFT_W'(in_x) << lvl_eff;
  assign sy_w      = gbs_pkg::SHIFT_W'(in_y) << lvl_eff;
  assign scale_ovf = (|sx_w[gbs_pkg::SHIFT_W-1:gbs_pkg::X_W]) ||
                     (|sy_w[gbs_pkg::SHIFT_W-1:gbs_pkg::X_W]);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign out_free      = !m_valid_q || m_axis_tready;

  assign prod = gbs_pkg::PROD_W'(row_q) * gbs_pkg::PROD_W'(grid_cols_q);
  assign idx  = gbs_pkg::IDX_W'(prod) + gbs_pkg::IDX_W'(col_q);

  assign keep = !mem_rdata.occ && (score_q > thr_q) &&
                (!mem_rdata.bval || (score_q > mem_rdata.score));

  gbs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (cell_size_q),
    .res_o      (div_res)
  );

  gbs_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (addr_q),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    cmd_d     = cmd_q;
    px_d      = px_q;
    py_d      = py_q;
    col_d     = col_q;
    row_d     = row_q;
    lvl_d     = lvl_q;
    score_d   = score_q;
    addr_d    = addr_q;
    res_d     = res_q;
    div_start = 1'b0;
    div_dvd   = px_q;
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = mem_rdata;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == gbs_pkg::CELL_AW'(gbs_pkg::MAX_CELLS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          cmd_d   = in_cmd;
          px_d    = sx_w[gbs_pkg::X_W-1:0];
          py_d    = sy_w[gbs_pkg::X_W-1:0];
          lvl_d   = in_lvl;
          score_d = in_score;
          case (in_cmd)
            gbs_pkg::CMD_MARK, gbs_pkg::CMD_OFFER: begin
              if ((cell_size_q != '0) && !scale_ovf &&
                  (32'(in_lvl) < gbs_pkg::MAX_LEVELS)) begin
                div_start = 1'b1;
                div_dvd   = sx_w[gbs_pkg::X_W-1:0];
                state_d   = ST_DIVX;
              end
            end
            gbs_pkg::CMD_READ: begin
              if (32'(in_sel) < gbs_pkg::MAX_CELLS) begin
                addr_d  = gbs_pkg::CELL_AW'(in_sel);
                state_d = ST_RD;
              end else begin
                res_d   = '0;
                state_d = ST_OUT;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_DIVX: begin
        if (div_res.done) begin
          col_d     = div_res.quo;
          div_start = 1'b1;
          div_dvd   = py_q;
          state_d   = ST_DIVY;
        end
      end
      ST_DIVY: begin
        if (div_res.done) begin
          row_d   = div_res.quo;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if ((gbs_pkg::X_W'(col_q) < gbs_pkg::X_W'(grid_cols_q) ||
             grid_cols_q[gbs_pkg::GCOL_W-1]) &&
            (32'(idx) < gbs_pkg::MAX_CELLS)) begin
          addr_d  = gbs_pkg::CELL_AW'(idx);
          state_d = ST_RD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_RD: begin
        // store read of addr_q lands at the end of this cycle
        state_d = ST_UPD;
      end
      ST_UPD: begin
        state_d = ST_IDLE;
        case (cmd_q)
          gbs_pkg::CMD_MARK: begin
            mem_we        = 1'b1;
            mem_wdata.occ = 1'b1;
          end
          gbs_pkg::CMD_OFFER: begin
            if (keep) begin
              mem_we    = 1'b1;
              mem_wdata = '{occ: 1'b0, bval: 1'b1, x: px_q, y: py_q,
                            lvl: lvl_q, score: score_q};
            end
          end
          gbs_pkg::CMD_READ: begin
            mem_we         = 1'b1;
            mem_wdata.occ  = 1'b0;
            mem_wdata.bval = 1'b0;
            res_d          = mem_rdata.bval ? mem_rdata : '0;
            state_d        = ST_OUT;
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_OUT: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_user_d  = res_q.bval;
          m_data_d  = '0;
          m_data_d[gbs_pkg::OUT_X_LSB +: gbs_pkg::X_W]         = res_q.x;
          m_data_d[gbs_pkg::OUT_Y_LSB +: gbs_pkg::X_W]         = res_q.y;
          m_data_d[gbs_pkg::OUT_LVL_LSB +: gbs_pkg::LVL_W]     = res_q.lvl;
          m_data_d[gbs_pkg::OUT_SCORE_LSB +: gbs_pkg::SCORE_W] = res_q.score;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      cmd_q       <= '0;
      m_valid_q   <= 1'b0;
      cell_size_q <= gbs_pkg::CELL_SIZE_RST;
      grid_cols_q <= gbs_pkg::GRID_COLS_RST;
      thr_q       <= '0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      cmd_q     <= cmd_d;
      m_valid_q <= m_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          gbs_pkg::REG_CELL_SIZE: cell_size_q <= cfg_data_i[gbs_pkg::CSIZE_W-1:0];
          gbs_pkg::REG_GRID_COLS: grid_cols_q <= cfg_data_i[gbs_pkg::GCOL_W-1:0];
          gbs_pkg::REG_THRESHOLD: thr_q       <= cfg_data_i[gbs_pkg::SCORE_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    px_q     <= px_d;
    py_q     <= py_d;
    col_q    <= col_d;
    row_q    <= row_d;
    lvl_q    <= lvl_d;
    score_q  <= score_d;
    addr_q   <= addr_d;
    res_q    <= res_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_data_q;
  assign m_axis_tuser[0] = m_user_q;

endmodule
`default_nettype wire

// ===== sv/gbs_chk.sv =====
// port-level checks for the grid bucket corner selector, bound to the top level
`default_nettype none
module gbs_chk (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            s_axis_tvalid,
  input wire logic                            s_axis_tready,
  input wire logic [gbs_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input wire logic [gbs_pkg::CMD_W-1:0]       s_axis_tuser,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [gbs_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input wire logic [0:0]                      m_axis_tuser,
  input wire logic                            cfg_valid_i,
  input wire logic                            cfg_ready_o,
  input wire logic [gbs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input wire logic [gbs_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // an empty cell reads back as all zeros
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("empty cell result carries data");

  // a kept corner beat a threshold, so its score is never zero
  a_kept_score: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      m_axis_tdata[gbs_pkg::OUT_SCORE_LSB +: gbs_pkg::SCORE_W] != '0)
    else $error("kept corner with zero score");

  // a read goes through the store, so the input side closes behind it
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == gbs_pkg::CMD_READ |=>
      !s_axis_tready)
    else $error("input taken during a cell read");

endmodule

bind grid_bucket_best_corner_select gbs_chk u_gbs_chk (.*);
`default_nettype wire

// ===== tb/tb_grid_bucket_best_corner_select.sv =====
// testbench of the grid bucket corner selector: directed and random words
`timescale 1ns / 1ps
module tb_grid_bucket_best_corner_select;

  localparam logic [gbs_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_WORDS    = 85;

  typedef struct packed {
    logic                        valid;
    logic [gbs_pkg::X_W-1:0]     x;
    logic [gbs_pkg::X_W-1:0]     y;
    logic [gbs_pkg::LVL_W-1:0]   lvl;
    logic [gbs_pkg::SCORE_W-1:0] score;
  } readout_t;

  logic                           clk_i;
  logic                           rst_ni = 1'b0;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [gbs_pkg::IN_DATA_W-1:0]  s_axis_tdata;
  logic [gbs_pkg::CMD_W-1:0]      s_axis_tuser;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [gbs_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0]                     m_axis_tuser;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [gbs_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [gbs_pkg::CFG_DATA_W-1:0] cfg_data_i;

  // grid state as the block should hold it
  logic [gbs_pkg::CSIZE_W-1:0] cell_size_q;
  logic [gbs_pkg::GCOL_W-1:0]  grid_cols_q;
  logic [gbs_pkg::SCORE_W-1:0] threshold_q;
  bit                          occ_map    [gbs_pkg::MAX_CELLS];
  bit                          kept_map   [gbs_pkg::MAX_CELLS];
  logic [gbs_pkg::X_W-1:0]     kept_x     [gbs_pkg::MAX_CELLS];
  logic [gbs_pkg::X_W-1:0]     kept_y     [gbs_pkg::MAX_CELLS];
  logic [gbs_pkg::LVL_W-1:0]   kept_lvl   [gbs_pkg::MAX_CELLS];
  logic [gbs_pkg::SCORE_W-1:0] kept_score [gbs_pkg::MAX_CELLS];

  readout_t pending_readouts[$];
  int       mismatch_count = 0;
  int       src_max_gap    = 16;
  int       sink_max_stall = 16;
  int       idle_cycles    = 0;

  grid_bucket_best_corner_select u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void grid_reset();
    cell_size_q = gbs_pkg::CELL_SIZE_RST;
    grid_cols_q = gbs_pkg::GRID_COLS_RST;
    threshold_q = '0;
    for (int i = 0; i < gbs_pkg::MAX_CELLS; i++) begin
      occ_map[i]    = 1'b0;
      kept_map[i]   = 1'b0;
      kept_x[i]     = '0;
      kept_y[i]     = '0;
      kept_lvl[i]   = '0;
      kept_score[i] = '0;
    end
  endfunction

  // cell number of a full-resolution pixel, 0 when it lies off the grid
  function automatic bit find_bucket(input int unsigned px, input int unsigned py,
                                     output int unsigned cell_no);
    int unsigned col;
    int unsigned row;
    int unsigned idx;
    cell_no = 0;
    if (cell_size_q == 0) return 1'b0;
    col = px / cell_size_q;
    row = py / cell_size_q;
    if (col >= grid_cols_q) return 1'b0;
    idx = row * grid_cols_q + col;
    if (idx >= gbs_pkg::MAX_CELLS) return 1'b0;
    cell_no = idx;
    return 1'b1;
  endfunction

  function automatic void bucket_update(input logic [gbs_pkg::CMD_W-1:0] cmd,
                                        input logic [gbs_pkg::X_W-1:0] x,
                                        input logic [gbs_pkg::X_W-1:0] y,
                                        input logic [gbs_pkg::LVL_W-1:0] lvl,
                                        input logic [gbs_pkg::SCORE_W-1:0] score,
                                        input logic [gbs_pkg::SEL_W-1:0] sel);
    int unsigned cell_no;
    int unsigned sx;
    int unsigned sy;
    readout_t    r;
    case (cmd)
      gbs_pkg::CMD_MARK: begin
        if (find_bucket(32'(x), 32'(y), cell_no)) occ_map[cell_no] = 1'b1;
      end
      gbs_pkg::CMD_OFFER: begin
        sx = int'(x) << lvl;
        sy = int'(y) << lvl;
        if (sx <= 4095 && sy <= 4095 && find_bucket(sx, sy, cell_no) && !occ_map[cell_no] &&
            score > threshold_q &&
            !(kept_map[cell_no] && score <= kept_score[cell_no])) begin
          kept_map[cell_no]   = 1'b1;
          kept_x[cell_no]     = sx[gbs_pkg::X_W-1:0];
          kept_y[cell_no]     = sy[gbs_pkg::X_W-1:0];
          kept_lvl[cell_no]   = lvl;
          kept_score[cell_no] = score;
        end
      end
      gbs_pkg::CMD_READ: begin
        r = '0;
        if (kept_map[sel]) begin
          r.valid = 1'b1;
          r.x     = kept_x[sel];
          r.y     = kept_y[sel];
          r.lvl   = kept_lvl[sel];
          r.score = kept_score[sel];
        end
        kept_map[sel] = 1'b0;
        occ_map[sel]  = 1'b0;
        pending_readouts = {pending_readouts, r};
      end
      default: ;
    endcase
  endfunction

  task automatic send_word(input logic [gbs_pkg::CMD_W-1:0] cmd,
                           input logic [gbs_pkg::X_W-1:0] x,
                           input logic [gbs_pkg::X_W-1:0] y,
                           input logic [gbs_pkg::LVL_W-1:0] lvl,
                           input logic [gbs_pkg::SCORE_W-1:0] score,
                           input logic [gbs_pkg::SEL_W-1:0] sel);
    int                            gap;
    logic [gbs_pkg::IN_DATA_W-1:0] word;
    gap = (src_max_gap > 0) ? $urandom_range(0, src_max_gap) : 0;
    word = '0;
    word[gbs_pkg::IN_X_LSB +: gbs_pkg::X_W]             = x;
    word[gbs_pkg::IN_Y_LSB +: gbs_pkg::X_W]             = y;
    word[gbs_pkg::IN_LVL_LSB +: gbs_pkg::LVL_W]         = lvl;
    word[gbs_pkg::IN_SCORE_LSB +: gbs_pkg::SCORE_W]     = score;
    word[gbs_pkg::IN_SEL_LSB +: gbs_pkg::SEL_W]         = sel;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    bucket_update(cmd, x, y, lvl, score, sel);
  endtask

  // drop valid, wait for every readout, then let a trailing mark or offer finish
  task automatic settle_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_readouts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [gbs_pkg::CFG_IDX_W-1:0] idx,
                         input logic [gbs_pkg::CFG_DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      gbs_pkg::REG_CELL_SIZE: cell_size_q = value[gbs_pkg::CSIZE_W-1:0];
      gbs_pkg::REG_GRID_COLS: grid_cols_q = value[gbs_pkg::GCOL_W-1:0];
      gbs_pkg::REG_THRESHOLD: threshold_q = value[gbs_pkg::SCORE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_grid(input logic [gbs_pkg::CSIZE_W-1:0] cs,
                          input logic [gbs_pkg::GCOL_W-1:0] gc,
                          input logic [gbs_pkg::SCORE_W-1:0] thr);
    settle_idle();
    put_reg(gbs_pkg::REG_CELL_SIZE, gbs_pkg::CFG_DATA_W'(cs));
    put_reg(gbs_pkg::REG_GRID_COLS, gbs_pkg::CFG_DATA_W'(gc));
    put_reg(gbs_pkg::REG_THRESHOLD, thr);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_readout(input logic got_valid,
                               input logic [gbs_pkg::OUT_DATA_W-1:0] data);
    readout_t want;
    if (pending_readouts.size() == 0) begin
      $display("%0t: unexpected readout word: expected none, got valid %0b data %h",
               $time, got_valid, data);
      mismatch_count++;
      return;
    end
    want = pending_readouts.pop_front();
    check_field("cell_valid", 32'(want.valid), 32'(got_valid));
    check_field("corner_x", 32'(want.x), 32'(data[gbs_pkg::OUT_X_LSB +: gbs_pkg::X_W]));
    check_field("corner_y", 32'(want.y), 32'(data[gbs_pkg::OUT_Y_LSB +: gbs_pkg::X_W]));
    check_field("corner_level", 32'(want.lvl),
                32'(data[gbs_pkg::OUT_LVL_LSB +: gbs_pkg::LVL_W]));
    check_field("corner_score", want.score,
                data[gbs_pkg::OUT_SCORE_LSB +: gbs_pkg::SCORE_W]);
  endtask

  initial begin : readout_sink
    int stall;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = (sink_max_stall > 0) ? $urandom_range(0, sink_max_stall) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      check_readout(m_axis_tuser[0], m_axis_tdata);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("grid_bucket_best_corner_select test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // empty read, first keep, equal kept score, read clears the cell
  task automatic test_empty_and_clear();
    send_word(gbs_pkg::CMD_READ, 12'd0, 12'd0, 3'd0, 32'd0, 10'd0);
    send_word(gbs_pkg::CMD_OFFER, 12'd3, 12'd5, 3'd0, 32'd1, 10'd0);
    send_word(gbs_pkg::CMD_OFFER, 12'd4, 12'd6, 3'd0, 32'd1, 10'd0);
    send_word(gbs_pkg::CMD_READ, 12'd0, 12'd0, 3'd0, 32'd0, 10'd0);
    send_word(gbs_pkg::CMD_READ, 12'd0, 12'd0, 3'd0, 32'd0, 10'd0);
  endtask

  task automatic test_field_extremes();
    send_word(gbs_pkg::CMD_OFFER, 12'hFFF, 12'hFFF, 3'd0, 32'hFFFF_FFFF, 10'h3FF);
    send_word(gbs_pkg::CMD_OFFER, 12'd1, 12'd1, 3'd7, 32'hFFFF_FFFF, 10'd0);
    // scaled column lands on 4096
    send_word(gbs_pkg::CMD_OFFER, 12'd32, 12'd1, 3'd7, 32'hFFFF_FFFF, 10'd0);
    send_word(gbs_pkg::CMD_OFFER, 12'd0, 12'd0, 3'd0, 32'd0, 10'd0);
    send_word(gbs_pkg::CMD_MARK, 12'd130, 12'd140, 3'd0, 32'd0, 10'd0);
    send_word(gbs_pkg::CMD_MARK, 12'd150, 12'd130, 3'd0, 32'd0, 10'd0);
    send_word(gbs_pkg::CMD_OFFER, 12'd75, 12'd65, 3'd1, 32'h8000_0000, 10'd0);
    send_word(CMD_UNUSED, 12'hFFF, 12'hFFF, 3'd7, 32'hFFFF_FFFF, 10'h3FF);
    send_word(gbs_pkg::CMD_READ, 12'd0, 12'd0, 3'd0, 32'd0, 10'd265);
    send_word(gbs_pkg::CMD_OFFER, 12'd75, 12'd65, 3'd1, 32'h8000_0000, 10'd0);
    send_word(gbs_pkg::CMD_READ, 12'd0, 12'd0, 3'd0, 32'd0, 10'd265);
    send_word(gbs_pkg::CMD_READ, 12'd0, 12'd0, 3'd0, 32'd0, 10'd264);
    send_word(gbs_pkg::CMD_READ, 12'd0, 12'd0, 3'd0, 32'd0, 10'h3FF);
  endtask

  task automatic test_grid_extremes();
    // zero cell size drops marks and offers
    set_grid(8'd0, 11'd32, 32'd0);
    send_word(gbs_pkg::CMD_MARK, 12'd0, 12'd0, 3'd0, 32'd0, 10'd0);
    send_word(gbs_pkg::CMD_OFFER, 12'd0, 12'd0, 3'd0, 32'd5, 10'd0);
    send_word(gbs_pkg::CMD_READ, 12'd0, 12'd0, 3'd0, 32'd0, 10'd0);
    // single column, score equal to threshold then just above
    set_grid(8'd255, 11'd1, 32'h0001_0000);
    send_word(gbs_pkg::CMD_OFFER, 12'd254, 12'd1000, 3'd0, 32'h0001_0000, 10'd0);
    send_word(gbs_pkg::CMD_OFFER, 12'd254, 12'd1000, 3'd0, 32'h0001_0001, 10'd0);
    send_word(gbs_pkg::CMD_OFFER, 12'd255, 12'd1000, 3'd0, 32'h0002_0000, 10'd0);
    send_word(gbs_pkg::CMD_READ, 12'd0, 12'd0, 3'd0, 32'd0, 10'd3);
    // widest grid: last cell, then first cell past the store
    set_grid(8'd1, 11'd1024, 32'd0);
    send_word(gbs_pkg::CMD_OFFER, 12'd1023, 12'd0, 3'd0, 32'd7, 10'd0);
    send_word(gbs_pkg::CMD_OFFER, 12'd0, 12'd1, 3'd0, 32'd9, 10'd0);
    send_word(gbs_pkg::CMD_READ, 12'd0, 12'd0, 3'd0, 32'd0, 10'h3FF);
  endtask

  task automatic random_word();
    int unsigned                 cs_eff;
    int unsigned                 col;
    int unsigned                 row;
    int unsigned                 max_row;
    int unsigned                 cell_no;
    int unsigned                 fx;
    int unsigned                 fy;
    int                          pick;
    logic [gbs_pkg::LVL_W-1:0]   lvl;
    logic [gbs_pkg::SCORE_W-1:0] score;
    cs_eff  = (cell_size_q == 0) ? 1 : cell_size_q;
    col     = $urandom_range(0, ((grid_cols_q < 6) ? grid_cols_q : 6) - 1);
    max_row = (gbs_pkg::MAX_CELLS - 1 - col) / grid_cols_q;
    row     = $urandom_range(0, (max_row < 4) ? max_row : 4);
    cell_no = row * grid_cols_q + col;
    fx      = col * cs_eff + $urandom_range(0, cs_eff - 1);
    fy      = row * cs_eff + $urandom_range(0, cs_eff - 1);
    if (fx > 4095) fx = 4095;
    if (fy > 4095) fy = 4095;
    lvl = gbs_pkg::LVL_W'($urandom_range(0, 7));
    case ($urandom_range(0, 3))
      0:       score = $urandom;
      1:       score = threshold_q + $urandom_range(0, 2);
      2:       score = kept_score[cell_no] - 1 + $urandom_range(0, 2);
      default: score = $urandom >> $urandom_range(0, 31);
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      send_word(gbs_pkg::CMD_W'($urandom_range(0, 3)), gbs_pkg::X_W'($urandom_range(0, 4095)),
                gbs_pkg::X_W'($urandom_range(0, 4095)), lvl, $urandom,
                gbs_pkg::SEL_W'($urandom_range(0, 1023)));
    end else if (pick < 55) begin
      send_word(gbs_pkg::CMD_OFFER, gbs_pkg::X_W'(fx >> lvl), gbs_pkg::X_W'(fy >> lvl), lvl,
                score, gbs_pkg::SEL_W'($urandom_range(0, 1023)));
    end else if (pick < 70) begin
      send_word(gbs_pkg::CMD_MARK, gbs_pkg::X_W'(fx), gbs_pkg::X_W'(fy), lvl, $urandom,
                gbs_pkg::SEL_W'($urandom_range(0, 1023)));
    end else begin
      send_word(gbs_pkg::CMD_READ, gbs_pkg::X_W'($urandom_range(0, 4095)),
                gbs_pkg::X_W'($urandom_range(0, 4095)), lvl, $urandom,
                cell_no[gbs_pkg::SEL_W-1:0]);
    end
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 5)
        0: set_grid(8'd16, 11'd32, 32'd0);
        1: set_grid(8'd1, 11'd1024, $urandom);
        2: set_grid(8'd255, 11'd1, 32'hFFFF_FFFF);
        3: set_grid(gbs_pkg::CSIZE_W'($urandom_range(1, 255)),
                    gbs_pkg::GCOL_W'($urandom_range(1, 1024)), $urandom >> 1);
        default: set_grid(gbs_pkg::CSIZE_W'($urandom_range(2, 20)),
                          gbs_pkg::GCOL_W'($urandom_range(1, 64)), $urandom >> 8);
      endcase
      // rotate through no idling, one side idling, both sides idling
      src_max_gap    = (p % 4 == 0 || p % 4 == 2) ? 0 : 16;
      sink_max_stall = (p % 4 == 0 || p % 4 == 1) ? 0 : 16;
      for (int i = 0; i < PHASE_WORDS; i++) random_word();
    end
  endtask

  initial begin
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    grid_reset();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_empty_and_clear();
    test_field_extremes();
    test_grid_extremes();
    test_random_traffic();
    settle_idle();
    if (mismatch_count == 0) begin
      $display("grid_bucket_best_corner_select test passed");
    end else begin
      $display("grid_bucket_best_corner_select test failed");
    end
    $finish;
  end

endmodule
